// File: hw/rtl/ultrasonic_echo_range_zoner_macros.svh
// Assertion macros used by the echo range zoner checker.
`ifndef ULTRASONIC_ECHO_RANGE_ZONER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGE_ZONER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define UERZ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("uerz check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define UERZ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("uerz check failed");

`endif

// File: hw/rtl/uerz_pkg.sv
// Package with types, constants and helper functions of the echo range zoner.
`timescale 1ns / 1ps
package uerz_pkg;

  localparam int unsigned SensorCount = 6;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned WidthBits = 16;
  localparam int unsigned AddrBits = 5;

  // Register indexes on the configuration port (word address bits [4:2])
  localparam logic [2:0] RegNear   = 3'd0;
  localparam logic [2:0] RegSecond = 3'd1;
  localparam logic [2:0] RegThird  = 3'd2;
  localparam logic [2:0] RegFar    = 3'd3;
  localparam logic [2:0] RegWait   = 3'd4;
  localparam logic [2:0] RegTrig   = 3'd5;

  // Register reset values
  localparam logic [15:0] NearDef   = 16'd700;
  localparam logic [15:0] SecondDef = 16'd1400;
  localparam logic [15:0] ThirdDef  = 16'd2360;
  localparam logic [15:0] FarDef    = 16'd3200;
  localparam logic [15:0] WaitDef   = 16'd9500;
  localparam logic [7:0]  TrigDef   = 8'd4;

  // Command codes
  localparam logic CmdTick  = 1'b0;
  localparam logic CmdStart = 1'b1;

  localparam logic [2:0] ZoneNone = 3'd0;
  localparam logic [2:0] ZoneFar  = 3'd5;

  typedef struct packed {
    logic       command;
    logic [2:0] direction;
    logic [5:0] echo_lines;
  } in_t;

  typedef struct packed {
    logic [5:0]  trigger_lines;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  zone;
    logic [15:0] last_width;
  } out_t;

  typedef struct packed {
    logic [15:0] near_threshold;
    logic [15:0] second_threshold;
    logic [15:0] third_threshold;
    logic [15:0] far_threshold;
    logic [15:0] wait_limit;
    logic [7:0]  trigger_ticks;
  } cfg_t;

  // Map an echo width to zones 1..5; first matching threshold wins.
  function automatic logic [2:0] classify(input logic [15:0] w, input cfg_t cfg);
    logic [2:0] z;
    if (w < cfg.near_threshold) begin
      z = 3'd1;
    end else if (w < cfg.second_threshold) begin
      z = 3'd2;
    end else if (w < cfg.third_threshold) begin
      z = 3'd3;
    end else if (w < cfg.far_threshold) begin
      z = 3'd4;
    end else begin
      z = ZoneFar;
    end
    return z;
  endfunction

  // First sensor covered by a valid direction.
  function automatic logic [2:0] first_sensor(input logic [1:0] dir);
    logic [2:0] s;
    case (dir)
      2'd0: s = 3'd0;
      2'd1: s = 3'd2;
      2'd2: s = 3'd3;
      2'd3: s = 3'd5;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // One-hot line for a sensor index, zero past the last sensor.
  function automatic logic [5:0] sensor_bit(input logic [2:0] idx);
    logic [5:0] b;
    if (32'(idx) < SensorCount) begin
      b = 6'(1) << idx;
    end else begin
      b = '0;
    end
    return b;
  endfunction

endpackage

// File: hw/rtl/uerz_cfg_regs.sv
// Configuration register file on the APB-style port.
`timescale 1ns / 1ps
module uerz_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uerz_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output uerz_pkg::cfg_t                cfg_o
);

  uerz_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_threshold   <= uerz_pkg::NearDef;
      cfg_q.second_threshold <= uerz_pkg::SecondDef;
      cfg_q.third_threshold  <= uerz_pkg::ThirdDef;
      cfg_q.far_threshold    <= uerz_pkg::FarDef;
      cfg_q.wait_limit       <= uerz_pkg::WaitDef;
      cfg_q.trigger_ticks    <= uerz_pkg::TrigDef;
    end else if (wr_en) begin
      case (reg_idx)
        uerz_pkg::RegNear:   cfg_q.near_threshold   <= pwdata[15:0];
        uerz_pkg::RegSecond: cfg_q.second_threshold <= pwdata[15:0];
        uerz_pkg::RegThird:  cfg_q.third_threshold  <= pwdata[15:0];
        uerz_pkg::RegFar:    cfg_q.far_threshold    <= pwdata[15:0];
        uerz_pkg::RegWait:   cfg_q.wait_limit       <= pwdata[15:0];
        uerz_pkg::RegTrig:   cfg_q.trigger_ticks    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      uerz_pkg::RegNear:   prdata = {16'd0, cfg_q.near_threshold};
      uerz_pkg::RegSecond: prdata = {16'd0, cfg_q.second_threshold};
      uerz_pkg::RegThird:  prdata = {16'd0, cfg_q.third_threshold};
      uerz_pkg::RegFar:    prdata = {16'd0, cfg_q.far_threshold};
      uerz_pkg::RegWait:   prdata = {16'd0, cfg_q.wait_limit};
      uerz_pkg::RegTrig:   prdata = {24'd0, cfg_q.trigger_ticks};
      default:             prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/uerz_core.sv
// Measurement sequencer: state registers and the combinational step logic.
`timescale 1ns / 1ps
module uerz_core #(
  parameter int unsigned COUNT_BITS = uerz_pkg::CountBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  uerz_pkg::in_t  item_i,
  input  uerz_pkg::cfg_t cfg_i,
  output uerz_pkg::out_t res_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhTrig = 2'd1;
  localparam logic [1:0] PhRise = 2'd2;
  localparam logic [1:0] PhHigh = 2'd3;

  localparam logic [31:0] CntMask = 32'((64'd1 << COUNT_BITS) - 64'd1);

  logic [1:0]            phase_q, phase_d;
  logic [COUNT_BITS-1:0] tick_q, tick_d, tick_inc;
  logic [2:0]            sensor_q, sensor_d;
  logic                  pair_q, pair_d;
  logic [2:0]            first_zone_q, first_zone_d;
  logic [15:0]           width_q, width_d;

  logic [31:0] lim_raw, lim, trig_len;
  logic        high;
  logic        fin;
  logic [15:0] fin_w;
  logic [2:0]  fin_zone;
  logic        done_tick, done_bad;

  assign lim_raw  = (cfg_i.wait_limit == '0) ? 32'd1 : 32'(cfg_i.wait_limit);
  assign lim      = (lim_raw > CntMask) ? CntMask : lim_raw;
  assign trig_len = (cfg_i.trigger_ticks == '0) ? 32'd1 : 32'(cfg_i.trigger_ticks);
  assign tick_inc = tick_q + COUNT_BITS'(1);
  assign high     = |(item_i.echo_lines & uerz_pkg::sensor_bit(sensor_q));
  assign fin_zone = uerz_pkg::classify(fin_w, cfg_i);

  always_comb begin
    phase_d      = phase_q;
    tick_d       = tick_q;
    sensor_d     = sensor_q;
    pair_d       = pair_q;
    first_zone_d = first_zone_q;
    width_d      = width_q;
    fin          = 1'b0;
    fin_w        = '0;
    done_tick    = 1'b0;
    done_bad     = 1'b0;

    if (item_i.command == uerz_pkg::CmdStart) begin
      // a start while busy is dropped
      if (phase_q == PhIdle) begin
        if (item_i.direction > 3'd3) begin
          done_bad = 1'b1;
        end else begin
          sensor_d     = uerz_pkg::first_sensor(item_i.direction[1:0]);
          pair_d       = !item_i.direction[0];
          first_zone_d = uerz_pkg::ZoneFar;
          tick_d       = '0;
          phase_d      = PhTrig;
        end
      end
    end else begin
      case (phase_q)
        PhTrig: begin
          if (32'(tick_inc) >= trig_len) begin
            tick_d  = '0;
            phase_d = PhRise;
          end else begin
            tick_d = tick_inc;
          end
        end
        PhRise: begin
          if (high) begin
            tick_d  = '0;
            phase_d = PhHigh;
          end else begin
            tick_d = tick_inc;
            if (32'(tick_inc) >= lim) begin
              fin   = 1'b1;
              fin_w = '0;   // missed rise reads as zero width
            end
          end
        end
        PhHigh: begin
          if (high) begin
            tick_d = tick_inc;
            if (32'(tick_inc) >= lim) begin
              fin   = 1'b1;
              fin_w = lim[15:0];
            end
          end else begin
            fin   = 1'b1;
            fin_w = 16'(tick_q);
          end
        end
        default: phase_d = PhIdle;
      endcase

      // close out one sensor; advance to the partner or finish the direction
      if (fin) begin
        width_d = fin_w;
        tick_d  = '0;
        if (pair_q) begin
          first_zone_d = fin_zone;
          pair_d       = 1'b0;
          sensor_d     = sensor_q + 3'd1;
          phase_d      = PhTrig;
        end else begin
          if (fin_zone < first_zone_q) begin
            first_zone_d = fin_zone;
          end
          phase_d   = PhIdle;
          done_tick = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      tick_q       <= '0;
      sensor_q     <= '0;
      pair_q       <= 1'b0;
      first_zone_q <= '0;
      width_q      <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      tick_q       <= tick_d;
      sensor_q     <= sensor_d;
      pair_q       <= pair_d;
      first_zone_q <= first_zone_d;
      width_q      <= width_d;
    end
  end

  always_comb begin
    res_o.trigger_lines = (phase_d == PhTrig) ? uerz_pkg::sensor_bit(sensor_d) : '0;
    res_o.busy_res      = (phase_d != PhIdle);
    res_o.done_res      = done_tick || done_bad;
    res_o.zone          = done_tick ? first_zone_d : uerz_pkg::ZoneNone;
    res_o.last_width    = width_d;
  end

endmodule

// File: hw/rtl/ultrasonic_echo_range_zoner.sv
// An accepted item is held in the input register; the step logic then writes its
//   result into the result register.
// Throughput: one item per cycle unless a result stalls; each tick is one pass.
// A stalled waiting result holds the staged item, which then stalls the input.
// Reset (rst_ni low, asynchronous): sequencer idle, counters and held width zero,
//   registers back to their defaults; both pipeline stages empty.
`timescale 1ns / 1ps
module ultrasonic_echo_range_zoner #(
  parameter int unsigned COUNT_BITS = uerz_pkg::CountBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  uerz_pkg::in_t                 in_data_i,
  // result output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output uerz_pkg::out_t                out_data_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uerz_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  uerz_pkg::cfg_t cfg;

  // Input stage: hold one item until the step logic consumes it.
  logic           in_vld_q, in_vld_d;
  uerz_pkg::in_t  in_q;
  logic           in_xfer;

  // Result stage: hold the result until the consumer takes it.
  logic           out_vld_q, out_vld_d;
  uerz_pkg::out_t out_q;
  uerz_pkg::out_t res;

  // Step when an item is staged and the result slot is free or draining.
  logic           advance;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  uerz_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  uerz_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

endmodule

// File: hw/rtl/uerz_checker.sv
// Port-level checker for the echo range zoner and its bind.
`timescale 1ns / 1ps
`include "ultrasonic_echo_range_zoner_macros.svh"
module uerz_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input uerz_pkg::in_t                 in_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input uerz_pkg::out_t                out_data_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [uerz_pkg::AddrBits-1:0] paddr,
  input logic [31:0]                   pwdata,
  input logic [31:0]                   prdata,
  input logic                          pready
);

  // a stalled result holds
  `UERZ_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // a nonzero zone only comes with a finished direction
  `UERZ_ASSERT_NOW(a_zone_done, out_valid_o && (out_data_o.zone != uerz_pkg::ZoneNone), out_data_o.done_res)

  // trigger drive is one-hot and only while busy
  `UERZ_ASSERT_NOW(a_trig_onehot, out_valid_o && (out_data_o.trigger_lines != 6'd0),
                   $onehot(out_data_o.trigger_lines) && out_data_o.busy_res)

  // zones stay in range
  `UERZ_ASSERT_NOW(a_zone_range, out_valid_o, out_data_o.zone <= uerz_pkg::ZoneFar)

endmodule

bind ultrasonic_echo_range_zoner uerz_checker u_uerz_checker (.*);

// File: verif/tb.sv
// Self-checking testbench for the ultrasonic echo range zoner.
`timescale 1ns / 1ps
module tb;
  import uerz_pkg::*;

  // Bound the run well past the slowest legal schedule (long trigger phase, full bursts).
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseGoal = 40;
  localparam int unsigned EchoSpanMax = 40;
  localparam logic [2:0] DirLast = 3'd3;

  // Sequencer phases of the ranging state machine as seen from outside.
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_TRIG,
    SEQ_RISE,
    SEQ_HIGH
  } seq_phase_e;

  typedef struct packed {
    seq_phase_e  ph;
    logic [15:0] ticks;
    logic [2:0]  sensor;
    logic        pair;
    logic [2:0]  zone_min;
    logic [15:0] width;
  } ranger_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrBits-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ultrasonic_echo_range_zoner dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Items waiting to be driven, and reports the block owes us, oldest first.
  in_t  item_queue[$];
  out_t pending_reports[$];

  // Register copy; set to the defaults at start, then written only by the config task, so generator and checker agree.
  cfg_t    live_cfg;
  // Checker copy of the sequencer, advanced on every accepted transfer.
  ranger_t live_state;
  // Generator copy, advanced as items are queued, used to shape the echo stream.
  ranger_t plan_state;

  int unsigned rise_delay;
  int unsigned echo_len;
  int unsigned phase_items;
  int unsigned mismatch_count;
  int unsigned transfers_in;
  int unsigned reports_checked;
  int unsigned directions_done;
  int unsigned cycle_count;
  int unsigned send_hold;
  int unsigned stall_hold;
  logic [5:0]  zones_seen;
  logic        idle_on;
  logic        in_taken;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [5:0] sensor_line(input logic [2:0] idx);
    return (32'(idx) < SensorCount) ? (6'd1 << idx) : 6'd0;
  endfunction

  // Thresholds are tried nearest first; the first one the width falls under wins.
  function automatic logic [2:0] zone_for_width(input logic [15:0] w, input cfg_t cfg);
    if (w < cfg.near_threshold) return 3'd1;
    if (w < cfg.second_threshold) return 3'd2;
    if (w < cfg.third_threshold) return 3'd3;
    if (w < cfg.far_threshold) return 3'd4;
    return ZoneFar;
  endfunction

  // Advance one sequencer copy by one item and form the report it produces.
  task automatic range_step(inout ranger_t st, input cfg_t cfg, input in_t it,
                            output out_t rep);
    logic        done;
    logic        fin;
    logic        hi;
    logic [15:0] fin_w;
    logic [15:0] lim;
    logic [15:0] len;
    logic [2:0]  z;
    logic [2:0]  z_out;
    done  = 1'b0;
    fin   = 1'b0;
    fin_w = '0;
    z_out = ZoneNone;
    // A zero limit or pulse length behaves as one tick.
    lim = (cfg.wait_limit == '0) ? 16'd1 : cfg.wait_limit;
    len = (cfg.trigger_ticks == '0) ? 16'd1 : 16'(cfg.trigger_ticks);
    if (it.command == CmdStart) begin
      // A start while busy is dropped; an invalid direction answers at once.
      if (st.ph == SEQ_IDLE) begin
        if (it.direction > DirLast) begin
          done = 1'b1;
        end else begin
          case (it.direction[1:0])
            2'd0: st.sensor = 3'd0;
            2'd1: st.sensor = 3'd2;
            2'd2: st.sensor = 3'd3;
            default: st.sensor = 3'd5;
          endcase
          st.pair     = (it.direction[1:0] == 2'd0) || (it.direction[1:0] == 2'd2);
          st.zone_min = ZoneFar;
          st.ticks    = '0;
          st.ph       = SEQ_TRIG;
        end
      end
    end else begin
      hi = |(it.echo_lines & sensor_line(st.sensor));
      case (st.ph)
        SEQ_TRIG: begin
          st.ticks = st.ticks + 16'd1;
          if (st.ticks >= len) begin
            st.ticks = '0;
            st.ph    = SEQ_RISE;
          end
        end
        SEQ_RISE: begin
          if (hi) begin
            st.ticks = '0;
            st.ph    = SEQ_HIGH;
          end else begin
            st.ticks = st.ticks + 16'd1;
            // Missed rise: report a width of zero.
            if (st.ticks >= lim) fin = 1'b1;
          end
        end
        SEQ_HIGH: begin
          if (hi) begin
            st.ticks = st.ticks + 16'd1;
            if (st.ticks >= lim) begin
              fin   = 1'b1;
              fin_w = lim;
            end
          end else begin
            fin   = 1'b1;
            fin_w = st.ticks;
          end
        end
        default: st.ph = SEQ_IDLE;
      endcase
      if (fin) begin
        z        = zone_for_width(fin_w, cfg);
        st.width = fin_w;
        st.ticks = '0;
        if (st.pair) begin
          // First of a pair: hold its zone and move on to the partner sensor.
          st.zone_min = z;
          st.pair     = 1'b0;
          st.sensor   = st.sensor + 3'd1;
          st.ph       = SEQ_TRIG;
        end else begin
          if (z < st.zone_min) st.zone_min = z;
          st.ph = SEQ_IDLE;
          done  = 1'b1;
        end
      end
      if (done) z_out = st.zone_min;
    end
    rep.trigger_lines = (st.ph == SEQ_TRIG) ? sensor_line(st.sensor) : 6'd0;
    rep.busy_res      = (st.ph != SEQ_IDLE);
    rep.done_res      = done;
    rep.zone          = z_out;
    rep.last_width    = st.width;
  endtask

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  // Pick where the echo rises and how long it stays up for the next sensor.
  task automatic draw_echo();
    int unsigned lim;
    int unsigned span;
    lim  = (live_cfg.wait_limit == '0) ? 1 : int'(live_cfg.wait_limit);
    span = (lim + 1 > EchoSpanMax) ? EchoSpanMax : lim + 1;
    rise_delay = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span) : $urandom_range(0, 2);
    echo_len   = $urandom_range(0, span);
  endtask

  // Queue one item and track what it does, so the stream can follow the sequencer.
  task automatic queue_item(input in_t it);
    out_t       scratch;
    logic       ignored;
    seq_phase_e prev;
    prev    = plan_state.ph;
    ignored = (it.command == CmdTick) ? (prev == SEQ_IDLE) : (prev != SEQ_IDLE);
    range_step(plan_state, live_cfg, it, scratch);
    if (!ignored) phase_items++;
    item_queue.push_back(it);
    if (plan_state.ph == SEQ_RISE && prev != SEQ_RISE) draw_echo();
  endtask

  task automatic queue_raw(input logic cmd, input logic [2:0] dir, input logic [5:0] echo);
    in_t it;
    it.command    = cmd;
    it.direction  = dir;
    it.echo_lines = echo;
    queue_item(it);
  endtask

  // A tick whose target pin follows the planned echo; all other pins are noise.
  task automatic queue_tick();
    logic [5:0] line;
    logic       hi;
    line = sensor_line(plan_state.sensor);
    hi   = (plan_state.ph == SEQ_RISE && plan_state.ticks >= rise_delay) ||
           (plan_state.ph == SEQ_HIGH && plan_state.ticks < echo_len);
    queue_raw(CmdTick, 3'($urandom), (6'($urandom) & ~line) | (hi ? line : 6'd0));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegNear:   live_cfg.near_threshold   = value;
      RegSecond: live_cfg.second_threshold = value;
      RegThird:  live_cfg.third_threshold  = value;
      RegFar:    live_cfg.far_threshold    = value;
      RegWait:   live_cfg.wait_limit       = value;
      RegTrig:   live_cfg.trigger_ticks    = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [2:0] idx, input logic [31:0] want);
    logic [31:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) flag_error($sformatf("register %0d read: expected %0d, got %0d",
                                           idx, want, got));
  endtask

  task automatic apply_setting(input logic [15:0] n, input logic [15:0] s,
                               input logic [15:0] t, input logic [15:0] f,
                               input logic [15:0] w, input logic [7:0] g);
    write_reg(RegNear, n);
    write_reg(RegSecond, s);
    write_reg(RegThird, t);
    write_reg(RegFar, f);
    write_reg(RegWait, w);
    write_reg(RegTrig, 16'(g));
  endtask

  // Hold the sender until every queued item is taken and every report is back.
  task automatic settle();
    while (item_queue.size() != 0 || in_valid_i || pending_reports.size() != 0)
      @(posedge clk_i);
    // Two-stage pipeline: let it go quiet before returning.
    repeat (4) @(posedge clk_i);
  endtask

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d reports outstanding",
               cycle_count, pending_reports.size());
      $display("** ultrasonic_echo_range_zoner: FAILED **");
      $finish;
    end
  end

  // Monitor: sample both handshakes at the rising edge, check reports, predict new ones.
  always @(posedge clk_i) begin : monitor
    out_t want;
    out_t got;
    out_t pred;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        reports_checked++;
        if (pending_reports.size() == 0) begin
          flag_error($sformatf("unexpected report %p", got));
        end else begin
          want = pending_reports.pop_front();
          if (got.trigger_lines !== want.trigger_lines || got.busy_res !== want.busy_res ||
              got.done_res !== want.done_res || got.zone !== want.zone ||
              got.last_width !== want.last_width) begin
            flag_error($sformatf({"report %0d: expected trig %b busy %b done %b zone %0d ",
                                  "width %0d, got trig %b busy %b done %b zone %0d width %0d"},
                                 reports_checked, want.trigger_lines, want.busy_res,
                                 want.done_res, want.zone, want.last_width,
                                 got.trigger_lines, got.busy_res, got.done_res, got.zone,
                                 got.last_width));
          end
        end
        if (got.done_res === 1'b1) begin
          directions_done++;
          zones_seen = zones_seen | (6'd1 << got.zone);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        in_taken = 1'b1;
        transfers_in++;
        range_step(live_state, live_cfg, in_data_i, pred);
        pending_reports.push_back(pred);
      end
    end
  end

  // Driver: move to the next item at the falling edge once the current one transferred.
  always @(negedge clk_i) begin : item_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (send_hold > 0) begin
        send_hold--;
        in_valid_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        send_hold = $urandom_range(0, 5);
        in_valid_i <= 1'b0;
      end else if (item_queue.size() != 0) begin
        in_data_i  <= item_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall the report side in random bursts while idling is on.
  always @(negedge clk_i) begin : report_stall
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_hold = $urandom_range(0, 5);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin : stimulus
    logic [15:0] lim;
    logic        paused;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    idle_on     = 1'b0;
    in_taken    = 1'b0;
    send_hold   = 0;
    stall_hold  = 0;
    cycle_count = 0;
    mismatch_count  = 0;
    transfers_in    = 0;
    reports_checked = 0;
    directions_done = 0;
    zones_seen  = '0;
    paused      = 1'b0;
    live_state  = '0;
    plan_state  = '0;
    live_cfg    = '{NearDef, SecondDef, ThirdDef, FarDef, WaitDef, TrigDef};
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Registers must come out of reset at their defaults.
    check_reg(RegNear, 32'(NearDef));
    check_reg(RegSecond, 32'(SecondDef));
    check_reg(RegThird, 32'(ThirdDef));
    check_reg(RegFar, 32'(FarDef));
    check_reg(RegWait, 32'(WaitDef));
    check_reg(RegTrig, 32'(TrigDef));

    // Directed part: zero pulse length and zero limit both act as one tick,
    // so every sensor finishes within a few items.
    apply_setting(16'd0, 16'd1, 16'd2, 16'd2, 16'd0, 8'd0);
    idle_on = 1'b1;
    queue_raw(CmdTick, 3'd0, 6'h3F);     // tick while idle
    queue_raw(CmdStart, 3'd1, 6'h3F);    // single sensor, echo on start ignored
    queue_raw(CmdTick, 3'd7, 6'h3F);     // echo during the trigger ignored
    queue_raw(CmdTick, 3'd0, 6'h00);     // missed rise
    queue_raw(CmdStart, 3'd0, 6'h00);    // pair of sensors
    queue_raw(CmdStart, 3'd3, 6'h00);    // start while busy
    queue_raw(CmdTick, 3'd0, 6'h00);
    queue_raw(CmdTick, 3'd0, 6'h01);     // rise
    queue_raw(CmdTick, 3'd0, 6'h01);     // width hits the limit
    queue_raw(CmdTick, 3'd0, 6'h3F);
    queue_raw(CmdTick, 3'd0, 6'h3E);     // other pins ignored, partner rises
    queue_raw(CmdTick, 3'd0, 6'h00);     // zero width
    queue_raw(CmdStart, 3'd7, 6'h3F);    // invalid direction
    queue_raw(CmdStart, 3'd4, 6'h00);    // invalid direction
    queue_raw(CmdStart, 3'd2, 6'h2A);
    queue_raw(CmdTick, 3'd0, 6'h00);
    queue_raw(CmdTick, 3'd0, 6'h08);
    queue_raw(CmdTick, 3'd0, 6'h08);
    queue_raw(CmdTick, 3'd0, 6'h00);
    queue_raw(CmdTick, 3'd0, 6'h37);     // partner pin high: rise
    queue_raw(CmdStart, 3'd3, 6'h00);
    queue_raw(CmdTick, 3'd0, 6'h00);
    queue_raw(CmdTick, 3'd0, 6'h20);
    queue_raw(CmdTick, 3'd0, 6'h00);
    settle();

    // Random part: one register setting per phase, extremes first.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'($urandom_range(1, 16)), 8'd1);
        1: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd2);
        2: apply_setting(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                         16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)), 16'd0, 8'd0);
        3: apply_setting(16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)),
                         16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)), 16'd5, 8'd30);
        default: begin
          lim = 16'($urandom_range(1, 30));
          apply_setting(16'($urandom_range(0, lim + 2)), 16'($urandom_range(0, lim + 2)),
                        16'($urandom_range(0, lim + 2)), 16'($urandom_range(0, lim + 2)),
                        lim, 8'($urandom_range(0, 8)));
        end
      endcase
      // No idling at all in the closing phases.
      idle_on     = (p < 6) && ($urandom_range(0, 3) != 0);
      phase_items = 0;
      while (phase_items < PhaseGoal || plan_state.ph != SEQ_IDLE) begin
        // Once, mid-measurement, drain everything before sending more.
        if (p == 4 && !paused && phase_items >= PhaseGoal / 2) begin
          settle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 19) == 0) begin
          queue_raw(1'($urandom), 3'($urandom), 6'($urandom));
        end else if (plan_state.ph == SEQ_IDLE) begin
          queue_raw(CmdStart, ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7))
                                                           : 3'($urandom_range(0, 3)),
                    6'($urandom));
        end else begin
          queue_tick();
        end
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    $display("covered %0d transfers in, %0d reports checked, %0d directions finished",
             transfers_in, reports_checked, directions_done);
    $display("zones reported on finish (bit per zone 0..5): %b", zones_seen);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("** ultrasonic_echo_range_zoner: PASSED **");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("** ultrasonic_echo_range_zoner: FAILED **");
    end
    $finish;
  end

endmodule
